>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros; the user scope must provide clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// expression that must never be true
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

>>> hw/rtl/mmpp_pkg.sv
// ----------------------------------------------------------------------------
// mmpp_pkg
// Types and constants shared by the min/max peak pyramid modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mmpp_pkg;

	localparam int SMP_W   = 24;
	localparam int BLK_W   = 32;
	localparam int FPP_W   = 17;
	localparam int LEVEL_W = 4;
	localparam int CC_W    = 2;

	typedef logic signed [SMP_W-1:0] smp_t;

	localparam smp_t SMP_MAX = smp_t'(24'h7F_FFFF);
	localparam smp_t SMP_MIN = smp_t'(24'h80_0000);

	localparam logic [FPP_W-1:0] FIB_SAT = 17'h1_FFFF;
	localparam logic [FPP_W-1:0] BS_MAX  = 17'h1_0000;
	localparam logic [BLK_W-1:0] BLK_SAT = 32'hFFFF_FFFF;

	// configuration register indexes
	localparam logic REG_CHANNEL_COUNT   = 1'b0;
	localparam logic REG_FRAMES_PER_PEAK = 1'b1;

	typedef struct packed {
		logic wr;      // write addressed entry, mark it valid
		logic clr_one; // drop addressed entry back to its reset value
		logic clr_all; // drop every entry
	} st_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ABS_RD,
		S_ABS_WR,
		S_LVL,
		S_CH_RD,
		S_CH_EMIT,
		S_PAR_RD,
		S_PAR_WR,
		S_FIN
	} mmpp_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/mmpp_cmp.sv
// ----------------------------------------------------------------------------
// mmpp_cmp
// Shared min/max unit: merges a (min, max) pair into a running pair.
// ----------------------------------------------------------------------------
`default_nettype none

module mmpp_cmp (
	input  mmpp_pkg::smp_t a_lo,
	input  mmpp_pkg::smp_t a_hi,
	input  mmpp_pkg::smp_t b_lo,
	input  mmpp_pkg::smp_t b_hi,
	output mmpp_pkg::smp_t lo,
	output mmpp_pkg::smp_t hi
);
	import mmpp_pkg::*;

	assign lo = (b_lo < a_lo) ? b_lo : a_lo;
	assign hi = (b_hi > a_hi) ? b_hi : a_hi;

endmodule

`default_nettype wire

>>> hw/rtl/mmpp_store.sv
// ----------------------------------------------------------------------------
// mmpp_store
// Running min/max memory, one entry per level and channel, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mmpp_store #(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mmpp_pkg::st_ctl_t        ctl,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  mmpp_pkg::smp_t           wr_lo,
	input  mmpp_pkg::smp_t           wr_hi,
	output mmpp_pkg::smp_t           rd_lo,
	output mmpp_pkg::smp_t           rd_hi
);
	import mmpp_pkg::*;

	logic [2*SMP_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]   valid_q;
	smp_t               rd_lo_q;
	smp_t               rd_hi_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[addr] <= {wr_hi, wr_lo};
		end
		// entry never written since the last clear reads as its reset value
		if (valid_q[addr]) begin
			rd_lo_q <= smp_t'(mem_q[addr][SMP_W-1:0]);
			rd_hi_q <= smp_t'(mem_q[addr][2*SMP_W-1:SMP_W]);
		end else begin
			rd_lo_q <= SMP_MAX;
			rd_hi_q <= SMP_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr_all) begin
			valid_q <= '0;
		end else if (ctl.wr) begin
			valid_q[addr] <= 1'b1;
		end else if (ctl.clr_one) begin
			valid_q[addr] <= 1'b0;
		end
	end

	assign rd_lo = rd_lo_q;
	assign rd_hi = rd_hi_q;

endmodule

`default_nettype wire

>>> hw/rtl/mmpp_seq.sv
// ----------------------------------------------------------------------------
// mmpp_seq
// Sequencer: absorbs frames, closes blocks level by level, drives results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mmpp_seq #(
	parameter int MAX_LEVELS = 16,
	parameter int FAN_IN     = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// frame side
	input  logic                                in_valid,
	output logic                                in_ready,
	input  mmpp_pkg::smp_t                      sample_first,
	input  mmpp_pkg::smp_t                      sample_second,
	input  logic                                final_frame,
	// configuration
	input  logic                                two_ch,
	input  logic [mmpp_pkg::FPP_W-1:0]          block_size,
	input  logic                                clr_stream,
	// store
	output mmpp_pkg::st_ctl_t                   st_ctl,
	output logic [$clog2(MAX_LEVELS):0]         st_addr,
	output mmpp_pkg::smp_t                      st_wlo,
	output mmpp_pkg::smp_t                      st_whi,
	input  mmpp_pkg::smp_t                      st_rlo,
	input  mmpp_pkg::smp_t                      st_rhi,
	// result side
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mmpp_pkg::LEVEL_W-1:0]        level,
	output logic                                channel,
	output logic [mmpp_pkg::BLK_W-1:0]          block_number,
	output mmpp_pkg::smp_t                      peak_min,
	output mmpp_pkg::smp_t                      peak_max,
	output logic                                status,
	output logic                                last
);
	import mmpp_pkg::*;

	localparam int LW  = $clog2(MAX_LEVELS);
	localparam int CGW = $clog2(FAN_IN + 1);
	localparam logic [LW-1:0] LV_TOP = LW'(MAX_LEVELS - 1);

	mmpp_state_t state_q, state_d;

	logic            ch_q;
	logic [LW-1:0]   lv_q;
	logic [FPP_W-1:0] fib_q;
	logic            final_q;
	logic            close_q;
	smp_t            smp0_q, smp1_q;
	logic [BLK_W-1:0] num_q;
	logic            close_next_q;
	smp_t            child_lo_q, child_hi_q;
	logic [CGW-1:0]  cg_q [MAX_LEVELS];
	logic [BLK_W-1:0] be_q [MAX_LEVELS];

	logic            out_valid_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic            out_ch_q;
	logic [BLK_W-1:0] out_num_q;
	smp_t            out_lo_q, out_hi_q;
	logic            out_status_q, out_last_q;

	logic            accept;
	logic            last_ch;
	logic            has_parent;
	logic [LW-1:0]   lv_next;
	logic [FPP_W-1:0] fib_inc;
	logic            close_now;
	logic [CGW-1:0]  cg_rd, cg_inc;
	logic [BLK_W-1:0] be_rd, be_inc;
	logic            close_next;
	logic            load;
	logic            chan_done;
	smp_t            cmp_b_lo, cmp_b_hi;
	smp_t            cmp_lo, cmp_hi;

	assign accept     = in_valid && in_ready;
	assign last_ch    = !two_ch || ch_q;
	assign has_parent = (lv_q != LV_TOP);
	assign lv_next    = lv_q + 1'b1;
	assign fib_inc    = (fib_q == FIB_SAT) ? fib_q : fib_q + 1'b1;
	assign close_now  = final_frame || (fib_inc >= block_size);
	assign cg_rd      = has_parent ? cg_q[lv_next] : '0;
	assign cg_inc     = cg_rd + 1'b1;
	assign be_rd      = be_q[lv_q];
	assign be_inc     = (be_rd == BLK_SAT) ? be_rd : be_rd + 1'b1;
	// the parent closes on a full set of children, or on flush when this
	// level has produced more than one block
	assign close_next = has_parent &&
		((cg_inc >= CGW'(FAN_IN)) || (final_q && (be_inc > 32'd1)));
	assign load       = (state_q == S_CH_EMIT) && (!out_valid_q || out_ready);
	assign chan_done  = (state_q == S_PAR_WR) || (load && !has_parent);

	mmpp_cmp u_cmp (
		.a_lo (st_rlo),
		.a_hi (st_rhi),
		.b_lo (cmp_b_lo),
		.b_hi (cmp_b_hi),
		.lo   (cmp_lo),
		.hi   (cmp_hi)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_ABS_RD;
			end
			S_ABS_RD: state_d = S_ABS_WR;
			S_ABS_WR: begin
				if (!last_ch) state_d = S_ABS_RD;
				else if (close_q) state_d = S_LVL;
				else state_d = S_IDLE;
			end
			S_LVL:   state_d = S_CH_RD;
			S_CH_RD: state_d = S_CH_EMIT;
			S_CH_EMIT: begin
				if (load) begin
					if (has_parent) state_d = S_PAR_RD;
					else if (!last_ch) state_d = S_CH_RD;
					else if (close_next_q) state_d = S_LVL;
					else state_d = S_FIN;
				end
			end
			S_PAR_RD: state_d = S_PAR_WR;
			S_PAR_WR: begin
				if (!last_ch) state_d = S_CH_RD;
				else if (close_next_q) state_d = S_LVL;
				else state_d = S_FIN;
			end
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready    = 1'b0;
		st_ctl      = '0;
		st_addr     = {lv_q, ch_q};
		cmp_b_lo    = child_lo_q;
		cmp_b_hi    = child_hi_q;
		case (state_q)
			S_IDLE: begin
				in_ready       = 1'b1;
				st_ctl.clr_all = clr_stream;
			end
			S_ABS_RD: st_addr = {{LW{1'b0}}, ch_q};
			S_ABS_WR: begin
				st_addr  = {{LW{1'b0}}, ch_q};
				st_ctl.wr = 1'b1;
				cmp_b_lo = ch_q ? smp1_q : smp0_q;
				cmp_b_hi = ch_q ? smp1_q : smp0_q;
			end
			S_CH_EMIT: st_ctl.clr_one = load;
			S_PAR_RD:  st_addr = {lv_next, ch_q};
			S_PAR_WR: begin
				st_addr   = {lv_next, ch_q};
				st_ctl.wr = 1'b1;
			end
			S_FIN: st_ctl.clr_all = final_q;
			default: ;
		endcase
	end

	assign st_wlo = cmp_lo;
	assign st_whi = cmp_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// stream control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q         <= 1'b0;
			lv_q         <= '0;
			fib_q        <= '0;
			final_q      <= 1'b0;
			close_q      <= 1'b0;
			close_next_q <= 1'b0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				cg_q[i] <= '0;
				be_q[i] <= '0;
			end
		end else if (clr_stream || (state_q == S_FIN && final_q)) begin
			fib_q <= '0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				cg_q[i] <= '0;
				be_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				final_q <= final_frame;
				close_q <= close_now;
				fib_q   <= close_now ? '0 : fib_inc;
				ch_q    <= 1'b0;
				lv_q    <= '0;
			end
			if (state_q == S_ABS_WR) begin
				ch_q <= !last_ch;
			end
			if (state_q == S_LVL) begin
				be_q[lv_q]   <= be_inc;
				close_next_q <= close_next;
				if (has_parent) begin
					cg_q[lv_next] <= close_next ? '0 : cg_inc;
				end
			end
			if (chan_done) begin
				ch_q <= !last_ch;
				if (last_ch && close_next_q) begin
					lv_q <= lv_next;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			smp0_q <= sample_first;
			smp1_q <= sample_second;
		end
		if (state_q == S_LVL) begin
			num_q <= be_rd;
		end
		if (load) begin
			child_lo_q   <= st_rlo;
			child_hi_q   <= st_rhi;
			out_level_q  <= LEVEL_W'(lv_q);
			out_ch_q     <= ch_q;
			out_num_q    <= num_q;
			out_lo_q     <= st_rlo;
			out_hi_q     <= st_rhi;
			out_status_q <= !has_parent && (num_q != '0);
			out_last_q   <= last_ch && !close_next_q;
		end
	end

	// result register, freed as soon as the receiver takes the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign level        = out_level_q;
	assign channel      = out_ch_q;
	assign block_number = out_num_q;
	assign peak_min     = out_lo_q;
	assign peak_max     = out_hi_q;
	assign status       = out_status_q;
	assign last         = out_last_q;

	`ASSERT_CLK(a_fib_below_block, (state_q == S_IDLE) |-> (fib_q < block_size),
		"frame count reached block size while idle")
	`ASSERT_NEVER(a_second_ch_unused, !two_ch && ch_q,
		"second channel selected with one channel configured")
	`ASSERT_NEVER(a_top_no_parent, (state_q == S_CH_RD) && !has_parent && close_next_q,
		"top level marked to close a parent")
	`ASSERT_CLK(a_last_ends_step, (load && last_ch && !close_next_q && !has_parent)
		|=> (state_q == S_FIN), "final result of a step not followed by wrap-up")

endmodule

`default_nettype wire

>>> hw/rtl/min_max_peak_pyramid.sv
// ----------------------------------------------------------------------------
// min_max_peak_pyramid
// Min/max waveform overview pyramid over a stream of one- or two-channel
// audio frames.
// ----------------------------------------------------------------------------
// Frames come in on the s_ channel, one item per frame; s_tlast marks the last
// frame of a source and flushes the open blocks upward. Peaks leave on the m_
// channel, level by level upward, channel 0 before channel 1; m_tlast marks the
// final peak caused by a frame. Registers are written on cfg_we; the user
// must write them only while idle, the block itself does not enforce it;
// any write restarts the stream. One shared min/max unit and one memory port
// do all the work. A frame that closes no block reads and rewrites one entry
// per channel; each closed level emits every channel and folds it into the
// parent (except at the top), then wraps up. s_tready is low in between.
// The result register frees the moment m_tready takes its item, so a stalled
// receiver holds the sequencer only when a new peak is ready to go out.
// Reset: channel_count 1, frames_per_peak 256, all running values empty and
// counters zero; the running store is cleared by valid bits, no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module min_max_peak_pyramid #(
	parameter int MAX_LEVELS = 16,
	parameter int FAN_IN     = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // sample_first[23:0], sample_second[47:24]
	input  logic        s_tlast,   // final_frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // level[3:0], block_number[35:4],
	                               // peak_min[59:36], peak_max[83:60], zero
	output logic [1:0]  m_tuser,   // channel[0], status[1]
	output logic        m_tlast,   // last
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import mmpp_pkg::*;

	localparam int DEPTH = 2 * MAX_LEVELS;

	logic [CC_W-1:0]  channel_count_q;
	logic [FPP_W-1:0] frames_per_peak_q;
	logic [FPP_W-1:0] block_size;

	st_ctl_t                  st_ctl;
	logic [$clog2(DEPTH)-1:0] st_addr;
	smp_t                     st_wlo, st_whi, st_rlo, st_rhi;

	logic [LEVEL_W-1:0] level;
	logic               channel;
	logic [BLK_W-1:0]   block_number;
	smp_t               peak_min, peak_max;
	logic               status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q   <= 2'd1;
			frames_per_peak_q <= 17'd256;
		end else if (cfg_we) begin
			case (cfg_index[0])
				REG_CHANNEL_COUNT:   channel_count_q   <= cfg_data[CC_W-1:0];
				REG_FRAMES_PER_PEAK: frames_per_peak_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, anything above 65536 as 65536
	always_comb begin
		if (frames_per_peak_q == '0) block_size = FPP_W'(1);
		else if (frames_per_peak_q > BS_MAX) block_size = BS_MAX;
		else block_size = frames_per_peak_q;
	end

	mmpp_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (st_ctl),
		.addr   (st_addr),
		.wr_lo  (st_wlo),
		.wr_hi  (st_whi),
		.rd_lo  (st_rlo),
		.rd_hi  (st_rhi)
	);

	mmpp_seq #(
		.MAX_LEVELS (MAX_LEVELS),
		.FAN_IN     (FAN_IN)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.sample_first  (smp_t'(s_tdata[23:0])),
		.sample_second (smp_t'(s_tdata[47:24])),
		.final_frame   (s_tlast),
		.two_ch        (channel_count_q[1]),
		.block_size    (block_size),
		.clr_stream    (cfg_we),
		.st_ctl        (st_ctl),
		.st_addr       (st_addr),
		.st_wlo        (st_wlo),
		.st_whi        (st_whi),
		.st_rlo        (st_rlo),
		.st_rhi        (st_rhi),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.level         (level),
		.channel       (channel),
		.block_number  (block_number),
		.peak_min      (peak_min),
		.peak_max      (peak_max),
		.status        (status),
		.last          (m_tlast)
	);

	assign m_tdata = {4'b0, peak_max, peak_min, block_number, level};
	assign m_tuser = {status, channel};

endmodule

`default_nettype wire

>>> tb/min_max_peak_pyramid_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_peak_pyramid_check
// Watches the frame, peak and register channels of the pyramid. Keeps its own
// running min/max store, per-level counters and register copies, works out
// the peaks each accepted frame should produce, and compares every peak that
// leaves the block with the oldest outstanding one.
// ----------------------------------------------------------------------------

module min_max_peak_pyramid_check #(
	parameter int MAX_LEVELS = 16,
	parameter int FAN_IN     = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [16:0] cfg_data,
	output int unsigned errors,
	output int unsigned pending
);
	import mmpp_pkg::*;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               channel;
		logic [BLK_W-1:0]   block_number;
		smp_t               peak_min;
		smp_t               peak_max;
		logic               status;
		logic               last;
	} peak_t;

	peak_t            peaks_due[$];
	peak_t            want;
	peak_t            got;
	logic [CC_W-1:0]  chan_cfg;
	logic [FPP_W-1:0] fpp_cfg;
	smp_t             lo_store[2*MAX_LEVELS];
	smp_t             hi_store[2*MAX_LEVELS];
	int unsigned      kids[MAX_LEVELS];
	logic [BLK_W-1:0] blk_cnt[MAX_LEVELS];
	logic [FPP_W-1:0] frame_cnt;
	int unsigned      fail_tally;

	assign errors = fail_tally;

	function automatic void note_fail(input string msg);
		fail_tally++;
		if (fail_tally <= 10)
			$display("%t: %s", $realtime, msg);
	endfunction

	function automatic string peak_str(input peak_t p);
		return $sformatf("lvl %0d ch %0d blk %0d min %0d max %0d st %0b last %0b",
			p.level, p.channel, p.block_number, p.peak_min, p.peak_max,
			p.status, p.last);
	endfunction

	function automatic void clear_stream();
		for (int i = 0; i < 2*MAX_LEVELS; i++) begin
			lo_store[i] = SMP_MAX;
			hi_store[i] = SMP_MIN;
		end
		for (int i = 0; i < MAX_LEVELS; i++) begin
			kids[i]    = 0;
			blk_cnt[i] = '0;
		end
		frame_cnt = '0;
	endfunction

	function automatic void fold(input int slot, input smp_t lo, input smp_t hi);
		if (lo < lo_store[slot])
			lo_store[slot] = lo;
		if (hi > hi_store[slot])
			hi_store[slot] = hi;
	endfunction

	// emit the open block of one level for every channel, pass it to the parent
	function automatic void close_block_level(input int lv, input int nch);
		peak_t            p;
		logic [BLK_W-1:0] num;
		int               slot;
		num = blk_cnt[lv];
		for (int c = 0; c < nch; c++) begin
			slot           = lv*2 + c;
			p.level        = LEVEL_W'(lv);
			p.channel      = c[0];
			p.block_number = num;
			p.peak_min     = lo_store[slot];
			p.peak_max     = hi_store[slot];
			p.status       = (lv == MAX_LEVELS-1) && (num != '0);
			p.last         = 1'b0;
			peaks_due      = {peaks_due, p};
			if (lv + 1 < MAX_LEVELS)
				fold(slot + 2, lo_store[slot], hi_store[slot]);
			lo_store[slot] = SMP_MAX;
			hi_store[slot] = SMP_MIN;
		end
		if (num != BLK_SAT)
			blk_cnt[lv] = num + 1'b1;
		kids[lv] = 0;
		if (lv + 1 < MAX_LEVELS)
			kids[lv+1]++;
	endfunction

	function automatic void frame_peaks(input smp_t a, input smp_t b, input logic fin);
		int               nch;
		int               lv;
		int               base;
		logic             shut;
		logic [FPP_W-1:0] bsize;
		nch  = (chan_cfg >= 2) ? 2 : 1;
		base = peaks_due.size();
		fold(0, a, a);
		if (nch == 2)
			fold(1, b, b);
		if (frame_cnt != FIB_SAT)
			frame_cnt = frame_cnt + 1'b1;
		if (fpp_cfg == '0)
			bsize = FPP_W'(1);
		else if (fpp_cfg > BS_MAX)
			bsize = BS_MAX;
		else
			bsize = fpp_cfg;
		shut = fin || (frame_cnt >= bsize);
		if (shut)
			frame_cnt = '0;
		lv = 0;
		while (shut && lv < MAX_LEVELS) begin
			close_block_level(lv, nch);
			if (lv + 1 >= MAX_LEVELS)
				shut = 1'b0;
			else
				shut = (kids[lv+1] >= FAN_IN) ||
					(fin && kids[lv+1] > 0 && blk_cnt[lv] > 1);
			lv++;
		end
		if (peaks_due.size() > base)
			peaks_due[peaks_due.size()-1].last = 1'b1;
		if (fin)
			clear_stream();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cfg   = CC_W'(1);
			fpp_cfg    = FPP_W'(256);
			clear_stream();
			peaks_due.delete();
			fail_tally = 0;
			pending   <= 0;
		end else begin
			// peaks leaving now belong to frames taken at earlier edges
			if (m_tvalid && m_tready) begin
				got.level        = m_tdata[3:0];
				got.block_number = m_tdata[35:4];
				got.peak_min     = m_tdata[59:36];
				got.peak_max     = m_tdata[83:60];
				got.channel      = m_tuser[0];
				got.status       = m_tuser[1];
				got.last         = m_tlast;
				if (peaks_due.size() == 0) begin
					note_fail({"unexpected peak: ", peak_str(got)});
				end else begin
					want = peaks_due.pop_front();
					if (got.level != want.level || got.channel != want.channel ||
						got.block_number != want.block_number ||
						got.peak_min != want.peak_min || got.peak_max != want.peak_max ||
						got.status != want.status || got.last != want.last ||
						m_tdata[87:84] != '0)
						note_fail({"peak mismatch: exp ", peak_str(want), " got ",
							peak_str(got), $sformatf(" pad %h", m_tdata[87:84])});
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_CHANNEL_COUNT:   chan_cfg = cfg_data[CC_W-1:0];
					REG_FRAMES_PER_PEAK: fpp_cfg  = cfg_data;
					default: ;
				endcase
				clear_stream();
			end
			if (s_tvalid && s_tready)
				frame_peaks(s_tdata[23:0], s_tdata[47:24], s_tlast);
			pending <= peaks_due.size();
		end
	end

endmodule

>>> tb/min_max_peak_pyramid_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_peak_pyramid_test
// Drives audio frames into the peak pyramid under a range of channel counts
// and block sizes: a short directed set of extreme samples and flushes, then
// random streams with random receiver stalls and sender gaps. The checker
// beside the block predicts and compares every peak.
// ----------------------------------------------------------------------------

module min_max_peak_pyramid_test;
	import mmpp_pkg::*;

	localparam int MAX_LEVELS  = 16;
	localparam int FAN_IN      = 4;
	localparam int RAND_ITEMS  = 130;
	localparam int CALM_AFTER  = 105;
	localparam int SETTLE      = 12;
	localparam int DRAIN       = 64;
	localparam int QUIET_LIMIT = 2000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;   // sample_first[23:0], sample_second[47:24]
	logic        s_tlast   = 1'b0; // final_frame
	logic        m_tvalid;
	logic        m_tready  = 1'b1;
	logic [87:0] m_tdata;          // level[3:0], block_number[35:4],
	                               // peak_min[59:36], peak_max[83:60], zero
	logic [1:0]  m_tuser;          // channel[0], status[1]
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic [0:0]  cfg_index = REG_CHANNEL_COUNT;
	logic [16:0] cfg_data  = '0;

	int unsigned errors;
	int unsigned pending;
	int unsigned quiet     = 0;
	int unsigned rx_left   = 0;
	logic        calm      = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	min_max_peak_pyramid #(
		.MAX_LEVELS(MAX_LEVELS),
		.FAN_IN    (FAN_IN)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	min_max_peak_pyramid_check #(
		.MAX_LEVELS(MAX_LEVELS),
		.FAN_IN    (FAN_IN)
	) peak_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	// receiver: random stall bursts between ready stretches
	always @(posedge clk) begin
		if (calm) begin
			m_tready <= 1'b1;
		end else if (rx_left == 0) begin
			if ($urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				rx_left  <= $urandom_range(1, 11);
			end else begin
				m_tready <= 1'b1;
				rx_left  <= $urandom_range(1, 30);
			end
		end else begin
			rx_left <= rx_left - 1;
		end
	end

	// cycles with no item moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("min_max_peak_pyramid_test: done, errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic smp_t pick_sample();
		case ($urandom_range(0, 9))
			0:       return SMP_MAX;
			1:       return SMP_MIN;
			default: return smp_t'($urandom);
		endcase
	endfunction

	// valid stays high from one item to the next unless a gap is drawn
	task automatic send_frame(input smp_t a, input smp_t b, input logic fin);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a};
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// registers only change once the block has gone idle
	task automatic reconfigure(input logic [CC_W-1:0] cc, input logic [FPP_W-1:0] fpp);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_CHANNEL_COUNT;
		cfg_data  <= {15'($urandom), cc};
		@(posedge clk);
		cfg_index <= REG_FRAMES_PER_PEAK;
		cfg_data  <= fpp;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int unsigned      rand_items;
		int unsigned      streams;
		int unsigned      len;
		logic             cut;
		logic [CC_W-1:0]  cc;
		logic [FPP_W-1:0] fpp;
		smp_t             a;
		smp_t             b;

		rand_items = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one channel, long blocks, flushed by the final frame
		send_frame(SMP_MAX, pick_sample(), 1'b0);
		send_frame(SMP_MIN, pick_sample(), 1'b0);
		send_frame('0, pick_sample(), 1'b1);

		// two channels via code 3, zero block size acts as one: flush climbs levels
		reconfigure(2'd3, 17'd0);
		for (int i = 0; i < 9; i++) begin
			case (i % 4)
				0:       begin a = SMP_MAX; b = SMP_MIN; end
				1:       begin a = SMP_MIN; b = SMP_MAX; end
				2:       begin a = '0;      b = '1;      end
				default: begin a = '1;      b = smp_t'(1); end
			endcase
			send_frame(a, b, i == 8);
		end

		// open block left behind, then dropped by the next write
		reconfigure(2'd2, 17'd2);
		repeat (3) send_frame(pick_sample(), pick_sample(), 1'b0);

		// channel code 0 and an oversized block
		reconfigure(2'd0, 17'h1_FFFF);
		send_frame(pick_sample(), pick_sample(), 1'b0);
		send_frame(pick_sample(), pick_sample(), 1'b1);

		// largest block; a new source starts straight after the final frame
		reconfigure(2'd2, BS_MAX);
		send_frame(SMP_MIN, SMP_MAX, 1'b0);
		send_frame(SMP_MAX, SMP_MIN, 1'b1);
		send_frame(pick_sample(), pick_sample(), 1'b0);
		send_frame(pick_sample(), pick_sample(), 1'b1);

		while (rand_items < RAND_ITEMS) begin
			cc = CC_W'($urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0:       fpp = '0;
				1:       fpp = FPP_W'($urandom_range(5, 12));
				2:       fpp = FPP_W'($urandom_range(65536, 131071));
				default: fpp = FPP_W'($urandom_range(1, 4));
			endcase
			reconfigure(cc, fpp);
			streams = $urandom_range(1, 3);
			for (int s = 0; s < streams && rand_items < RAND_ITEMS; s++) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48)
					: $urandom_range(1, 12);
				if (len > RAND_ITEMS - rand_items)
					len = RAND_ITEMS - rand_items;
				cut = ($urandom_range(0, 7) == 0);
				for (int k = 0; k < len; k++) begin
					send_frame(pick_sample(), pick_sample(), (k == len - 1) && !cut);
					rand_items++;
					if (rand_items >= CALM_AFTER)
						calm = 1'b1;
				end
			end
		end

		wait_drained();
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("min_max_peak_pyramid_test: done, clean");
		else
			$display("min_max_peak_pyramid_test: done, errors");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/mmpp_pkg.sv
hw/rtl/mmpp_cmp.sv
hw/rtl/mmpp_store.sv
hw/rtl/mmpp_seq.sv
hw/rtl/min_max_peak_pyramid.sv
tb/min_max_peak_pyramid_check.sv
tb/min_max_peak_pyramid_test.sv
